// ----- hw/rtl/mld_pkg.sv -----
package mld_pkg;

  // Number of entries in the character table: A to Z, then 0 to 9.
  localparam int unsigned NumGlyphs = 36;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 3;

  // ASCII code of the space that follows a word gap.
  localparam logic [6:0] SpaceChar = 7'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 3'd0,
    CfgDotTicks  = 3'd1,
    CfgDashTicks = 3'd2,
    CfgLetterGap = 3'd3,
    CfgWordGap   = 3'd4
  } cfg_idx_e;

  // One result item as it waits in the output register.
  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } res_t;

  // Outcome of a table lookup on the pending symbol.
  typedef struct packed {
    logic       hit;
    logic [6:0] char_code;
  } dec_t;

  // Number of elements in each pattern.
  localparam logic [2:0] PatLen [NumGlyphs] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // Element i of a pattern sits at bit i; a set bit is a dash.
  localparam logic [4:0] PatBits [NumGlyphs] = '{
    5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,
    5'd14, 5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,
    5'd0,  5'd1,  5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15
  };

  localparam logic [6:0] Glyph [NumGlyphs] = '{
    7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72, 7'd73,
    7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82,
    7'd83, 7'd84, 7'd85, 7'd86, 7'd87, 7'd88, 7'd89, 7'd90,
    7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57
  };

endpackage

// ----- hw/rtl/morse_light_decoder.sv -----
// Morse decoder for a sampled light level.
// Input channel: one level_mv_i sample per item, taken when in_valid_i is high
// and in_stall_o is low. Output channel: char_code_o and last_o, taken when
// out_valid_o is high and out_stall_i is low; a sample yields zero, one or two
// items, and last_o marks the final item of a sample.
// Configuration: cfg_index_i selects threshold, dot, dash, letter gap or word
// gap; the write lands when cfg_valid_i and cfg_ready_o are both high. The
// port is always ready, and it is meant to be written while the block is idle.
// An accepted sample waits in the input register until it is processed, and
// its results are then loaded into the output register, where the first one
// is offered.
// Throughput: one sample per cycle while the receiver keeps taking results.
// The two-entry output register sets the pace: a sample is only processed
// once that register empties, so after a sample that makes two items
// (character and space) the next sample waits until the space is taken.
// Reset clears run counters, pending symbol and both handshakes, and loads
// the register defaults. While out_stall_i blocks an offered item, it holds,
// the next sample waits in the input register and in_stall_o is raised.
module morse_light_decoder #(
  parameter int unsigned COUNT_WIDTH = 8,
  parameter int unsigned MAX_SYMBOLS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] level_mv_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  char_code_o,
  output logic        last_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mld_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  // Run lengths are compared against the 8 bit registers at whichever width
  // is larger, so a saturated short counter still compares correctly.
  localparam int unsigned CntW    = COUNT_WIDTH;
  localparam int unsigned MatchW  = (CntW > 8) ? CntW : 8;
  localparam int unsigned SymW    = MAX_SYMBOLS;
  localparam int unsigned SymLenW = $clog2(MAX_SYMBOLS + 1);

  // Configuration registers.
  logic [11:0] thr_q;
  logic [7:0]  dot_q, dash_q, letter_q, word_q;

  // Input register.
  logic        in_vld_q, in_vld_d;
  logic [11:0] level_q;

  // Decoder state.
  logic [CntW-1:0]    on_run_q, on_run_d, off_run_q, off_run_d;
  logic [SymW-1:0]    sym_bits_q, sym_bits_d;
  logic [SymLenW-1:0] sym_len_q, sym_len_d;
  logic               sym_ovf_q, sym_ovf_d;

  // Output register: up to two items, entry 0 is the one on offer.
  mld_pkg::res_t res_q [2];
  mld_pkg::res_t res_d [2];
  logic [1:0]    res_cnt_q, res_cnt_d;

  logic          in_accept, out_pop, proc;
  logic [1:0]    cnt_after_pop;
  logic          lvl_on;
  logic          letter_hit, word_hit, dot_hit, dash_hit;
  mld_pkg::dec_t dec;
  mld_pkg::res_t new_res [2];
  logic [1:0]    new_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= 12'd110;
      dot_q    <= 8'd1;
      dash_q   <= 8'd2;
      letter_q <= 8'd4;
      word_q   <= 8'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mld_pkg::cfg_idx_e'(cfg_index_i))
        mld_pkg::CfgThreshold: thr_q    <= cfg_data_i;
        mld_pkg::CfgDotTicks:  dot_q    <= cfg_data_i[7:0];
        mld_pkg::CfgDashTicks: dash_q   <= cfg_data_i[7:0];
        mld_pkg::CfgLetterGap: letter_q <= cfg_data_i[7:0];
        mld_pkg::CfgWordGap:   word_q   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Handshakes. A sample is processed only when the output register will be
  // empty after this cycle's pop, so its results always fit.
  assign out_valid_o   = (res_cnt_q != 2'd0);
  assign out_pop       = out_valid_o && !out_stall_i;
  assign cnt_after_pop = res_cnt_q - {1'b0, out_pop};
  assign proc          = in_vld_q && (cnt_after_pop == 2'd0);
  assign in_stall_o    = in_vld_q && !proc;
  assign in_accept     = in_valid_i && !in_stall_o;
  assign in_vld_d      = in_accept | (in_vld_q & !proc);

  assign char_code_o = res_q[0].char_code;
  assign last_o      = res_q[0].last;

  mld_decode #(
    .SymW    (SymW),
    .SymLenW (SymLenW)
  ) u_decode (
    .sym_bits_i     (sym_bits_q),
    .sym_len_i      (sym_len_q),
    .sym_overflow_i (sym_ovf_q),
    .dec_o          (dec)
  );

  // A register holding zero never matches a run. Dot wins over dash and the
  // letter gap wins over the word gap when both registers are equal.
  assign lvl_on     = (level_q >= thr_q);
  assign letter_hit = (letter_q != 8'd0) && (MatchW'(off_run_q) == MatchW'(letter_q));
  assign word_hit   = !letter_hit && (word_q != 8'd0) &&
                      (MatchW'(off_run_q) == MatchW'(word_q));
  assign dot_hit    = (dot_q != 8'd0) && (MatchW'(on_run_q) == MatchW'(dot_q));
  assign dash_hit   = !dot_hit && (dash_q != 8'd0) &&
                      (MatchW'(on_run_q) == MatchW'(dash_q));

  always_comb begin
    on_run_d   = on_run_q;
    off_run_d  = off_run_q;
    sym_bits_d = sym_bits_q;
    sym_len_d  = sym_len_q;
    sym_ovf_d  = sym_ovf_q;
    new_res[0] = '{char_code: dec.char_code, last: 1'b1};
    new_res[1] = '{char_code: mld_pkg::SpaceChar, last: 1'b1};
    new_cnt    = 2'd0;
    if (proc) begin
      if (lvl_on) begin
        on_run_d  = (on_run_q == '1) ? on_run_q : on_run_q + 1'b1;
        off_run_d = '0;
        if (letter_hit || word_hit) begin
          sym_bits_d = '0;
          sym_len_d  = '0;
          sym_ovf_d  = 1'b0;
          if (letter_hit) begin
            new_cnt = {1'b0, dec.hit};
          end else if (dec.hit) begin
            new_res[0].last = 1'b0;
            new_cnt         = 2'd2;
          end else begin
            new_res[0] = new_res[1];
            new_cnt    = 2'd1;
          end
        end
      end else begin
        off_run_d = (off_run_q == '1) ? off_run_q : off_run_q + 1'b1;
        on_run_d  = '0;
        if ((dot_hit || dash_hit) && !sym_ovf_q) begin
          if (sym_len_q >= SymLenW'(MAX_SYMBOLS)) begin
            sym_ovf_d = 1'b1;
          end else begin
            for (int i = 0; i < SymW; i++) begin
              if (sym_len_q == SymLenW'(i)) begin
                sym_bits_d[i] = dash_hit;
              end
            end
            sym_len_d = sym_len_q + 1'b1;
          end
        end
      end
    end
  end

  // Output register update: shift on a pop, load when a processed sample makes items.
  always_comb begin
    res_d     = res_q;
    res_cnt_d = cnt_after_pop;
    if (out_pop) begin
      res_d[0] = res_q[1];
    end
    if (proc && (new_cnt != 2'd0)) begin
      res_d     = new_res;
      res_cnt_d = new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      on_run_q   <= '0;
      off_run_q  <= '0;
      sym_bits_q <= '0;
      sym_len_q  <= '0;
      sym_ovf_q  <= 1'b0;
      res_cnt_q  <= 2'd0;
    end else begin
      in_vld_q   <= in_vld_d;
      on_run_q   <= on_run_d;
      off_run_q  <= off_run_d;
      sym_bits_q <= sym_bits_d;
      sym_len_q  <= sym_len_d;
      sym_ovf_q  <= sym_ovf_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= level_mv_i;
    end
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  // The output register never holds more than two items.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_cnt_q != 2'd3)
    else $error("output register holds more than two items");

  // A pair of items is always a character followed by the closing space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q == 2'd2) |-> (!res_q[0].last && res_q[1].last &&
                             (res_q[1].char_code == mld_pkg::SpaceChar)))
    else $error("malformed item pair in output register");

  // A lone item closes its sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q == 2'd1) |-> res_q[0].last)
    else $error("single pending item not marked last");

  // The input side only stalls while a sample waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> in_vld_q)
    else $error("input stalled with empty input register");
`endif

endmodule

// ----- hw/rtl/mld_decode.sv -----
module mld_decode #(
  parameter int unsigned SymW    = 6,
  parameter int unsigned SymLenW = 3
) (
  input  logic [SymW-1:0]    sym_bits_i,
  input  logic [SymLenW-1:0] sym_len_i,
  input  logic               sym_overflow_i,
  output mld_pkg::dec_t      dec_o
);

  // Every table entry is compared in parallel; the patterns are distinct, so
  // at most one entry can hit.
  always_comb begin
    dec_o = '0;
    if (!sym_overflow_i) begin
      for (int i = 0; i < mld_pkg::NumGlyphs; i++) begin
        if ((sym_len_i == SymLenW'(mld_pkg::PatLen[i])) &&
            (sym_bits_i == SymW'(mld_pkg::PatBits[i]))) begin
          dec_o.hit       = 1'b1;
          dec_o.char_code = mld_pkg::Glyph[i];
        end
      end
    end
  end

endmodule
